// File: design/ask_fsk_psk_modulator_defines.svh
// ---------------------------------------------------------------------------
// ask_fsk_psk_modulator_defines.svh
// Assertion macros shared by the modulator RTL.
// ---------------------------------------------------------------------------
`ifndef ASK_FSK_PSK_MODULATOR_DEFINES_SVH
`define ASK_FSK_PSK_MODULATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define AFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afp: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define AFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afp: next-cycle check failed");

`endif

// File: design/afp_pkg.sv
// ---------------------------------------------------------------------------
// afp_pkg
// Widths, register map, types and the quarter-wave sine table.
// ---------------------------------------------------------------------------
package afp_pkg;

    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS    = 16;

    localparam int INC_BITS      = 32;
    localparam int AMP_BITS      = 15;
    localparam int AMP_FRAC      = 14;
    localparam int QUARTER_BITS  = SINE_ADDR_BITS - 2;
    localparam int QUARTER_LEN   = 1 << QUARTER_BITS;
    localparam int MAG_BITS      = SAMPLE_BITS - 1;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    typedef logic [PHASE_BITS-1:0]           t_phase;
    typedef logic [INC_BITS-1:0]             t_inc;
    typedef logic [AMP_BITS-1:0]             t_amp;
    typedef logic [SINE_ADDR_BITS-1:0]       t_sine_addr;
    typedef logic [MAG_BITS-1:0]             t_mag;
    typedef logic signed [SAMPLE_BITS-1:0]   t_sample;
    typedef logic [APB_ADDR_BITS-1:0]        t_apb_addr;
    typedef logic [APB_DATA_BITS-1:0]        t_apb_data;

    // register indexes, byte address = 4 * index
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_CARRIER_INC   = 3'd0,
        REG_TONE_ZERO_INC = 3'd1,
        REG_TONE_ONE_INC  = 3'd2,
        REG_AMP_ZERO      = 3'd3,
        REG_AMP_ONE       = 3'd4
    } t_reg_idx;

    localparam t_inc RST_CARRIER_INC   = 32'd42949673;
    localparam t_inc RST_TONE_ZERO_INC = 32'd64424509;
    localparam t_inc RST_TONE_ONE_INC  = 32'd85899346;
    localparam t_amp RST_AMP_ZERO      = 15'd8192;
    localparam t_amp RST_AMP_ONE       = 15'd24576;

    typedef struct packed {
        t_inc carrier_inc;
        t_inc tone_zero_inc;
        t_inc tone_one_inc;
        t_amp amp_zero;
        t_amp amp_one;
    } t_cfg;

    // table addresses for one tick, handed from the phase stage
    typedef struct packed {
        logic       data_bit;
        t_sine_addr carrier_addr;
        t_sine_addr fsk_addr;
        t_sine_addr psk_addr;
    } t_lookup;

    // quarter-wave table, QUARTER_LEN + 1 entries
    typedef logic [QUARTER_LEN:0][MAG_BITS-1:0] t_sine_tab;

    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
    localparam int          ANGLE_SHIFT = QUARTER_BITS + 1;
    localparam int          TAB_SHIFT = 30 - (SAMPLE_BITS - 2);
    localparam logic [63:0] TAB_ROUND = 64'd1 << (TAB_SHIFT - 1);
    localparam logic [63:0] SINE_ONE  = 64'd1 << (SAMPLE_BITS - 2);

    // Taylor term divisors (2j)(2j+1) as reciprocals: for n < 2^63 and
    // d <= 512, floor(n / d) is (n * ceil(2^72 / d)) >> 72 exactly
    localparam int TAYLOR_TERMS = 9;
    localparam int RECIP_SHIFT  = 72;
    localparam int RECIP_BITS   = 72;
    localparam int WIDE_BITS    = 136;
    localparam logic [WIDE_BITS-1:0] RECIP_ONE = 136'd1 << RECIP_SHIFT;
    localparam logic [1:TAYLOR_TERMS][RECIP_BITS-1:0] TAYLOR_RECIP = {
        RECIP_BITS'((RECIP_ONE + 136'd5) / 136'd6),
        RECIP_BITS'((RECIP_ONE + 136'd19) / 136'd20),
        RECIP_BITS'((RECIP_ONE + 136'd41) / 136'd42),
        RECIP_BITS'((RECIP_ONE + 136'd71) / 136'd72),
        RECIP_BITS'((RECIP_ONE + 136'd109) / 136'd110),
        RECIP_BITS'((RECIP_ONE + 136'd155) / 136'd156),
        RECIP_BITS'((RECIP_ONE + 136'd209) / 136'd210),
        RECIP_BITS'((RECIP_ONE + 136'd271) / 136'd272),
        RECIP_BITS'((RECIP_ONE + 136'd341) / 136'd342)
    };

    // Q30 Taylor series, truncating, evaluated at elaboration only
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab            tab;
        logic [63:0]          x;
        logic [63:0]          x2;
        logic [63:0]          term;
        logic [63:0]          s;
        logic [63:0]          v;
        logic [WIDE_BITS-1:0] wide;
        logic signed [63:0]   sum;
        tab = '0;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            x    = (64'(k) * PI_Q30) >> ANGLE_SHIFT;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int j = 1; j <= TAYLOR_TERMS; j++) begin
                wide = WIDE_BITS'(term * x2) * WIDE_BITS'(TAYLOR_RECIP[j]);
                term = 64'(wide >> RECIP_SHIFT);
                term = term >> 30;
                if ((j % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            s = (sum < 0) ? 64'd0 : $unsigned(sum);
            if (s > ONE_Q30) begin
                s = ONE_Q30;
            end
            v = (s + TAB_ROUND) >> TAB_SHIFT;
            if (v > SINE_ONE) begin
                v = SINE_ONE;
            end
            tab[k] = v[MAG_BITS-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

    // quadrant fold: odd quadrants mirror, upper half negates
    function automatic t_sample sine_lookup(t_sine_addr addr);
        logic [1:0]              quad;
        logic [QUARTER_BITS-1:0] idx;
        logic [QUARTER_BITS:0]   pos;
        t_mag                    mag;
        t_sample                 pos_val;
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        idx  = addr[QUARTER_BITS-1:0];
        if (quad[0]) begin
            pos = (QUARTER_BITS+1)'(QUARTER_LEN) - {1'b0, idx};
        end else begin
            pos = {1'b0, idx};
        end
        mag     = SINE_TAB[pos];
        pos_val = $signed({1'b0, mag});
        return quad[1] ? -pos_val : pos_val;
    endfunction

endpackage

// File: design/afp_if.sv
// ---------------------------------------------------------------------------
// afp_if
// Valid/ready stream interfaces: sample tick in, sample set out.
// ---------------------------------------------------------------------------
interface afp_tick_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic restart;

    modport source (output valid, output data_bit, output restart, input ready);
    modport sink   (input valid, input data_bit, input restart, output ready);
endinterface

interface afp_sample_if;
    import afp_pkg::*;

    logic    valid;
    logic    ready;
    t_sample ask_sample;
    t_sample fsk_sample;
    t_sample psk_sample;

    modport source (output valid, output ask_sample, output fsk_sample, output psk_sample,
                    input ready);
    modport sink   (input valid, input ask_sample, input fsk_sample, input psk_sample,
                    output ready);
endinterface

// File: design/afp_cfg_regs.sv
// ---------------------------------------------------------------------------
// afp_cfg_regs
// APB register file: three phase increments and two ASK amplitudes.
// ---------------------------------------------------------------------------
module afp_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  afp_pkg::t_apb_addr paddr,
    input  afp_pkg::t_apb_data pwdata,
    output afp_pkg::t_apb_data prdata,
    output logic               pready,
    output afp_pkg::t_cfg      o_cfg
);
    import afp_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_CARRIER_INC:   n_cfg.carrier_inc   = pwdata[INC_BITS-1:0];
                REG_TONE_ZERO_INC: n_cfg.tone_zero_inc = pwdata[INC_BITS-1:0];
                REG_TONE_ONE_INC:  n_cfg.tone_one_inc  = pwdata[INC_BITS-1:0];
                REG_AMP_ZERO:      n_cfg.amp_zero      = pwdata[AMP_BITS-1:0];
                REG_AMP_ONE:       n_cfg.amp_one       = pwdata[AMP_BITS-1:0];
                default:           n_cfg = r_cfg;  // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CARRIER_INC:   prdata = APB_DATA_BITS'(r_cfg.carrier_inc);
            REG_TONE_ZERO_INC: prdata = APB_DATA_BITS'(r_cfg.tone_zero_inc);
            REG_TONE_ONE_INC:  prdata = APB_DATA_BITS'(r_cfg.tone_one_inc);
            REG_AMP_ZERO:      prdata = APB_DATA_BITS'(r_cfg.amp_zero);
            REG_AMP_ONE:       prdata = APB_DATA_BITS'(r_cfg.amp_one);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.carrier_inc   <= RST_CARRIER_INC;
            r_cfg.tone_zero_inc <= RST_TONE_ZERO_INC;
            r_cfg.tone_one_inc  <= RST_TONE_ONE_INC;
            r_cfg.amp_zero      <= RST_AMP_ZERO;
            r_cfg.amp_one       <= RST_AMP_ONE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: design/afp_phase_gen.sv
// ---------------------------------------------------------------------------
// afp_phase_gen
// Three phase accumulators; registers the table addresses of each tick.
// ---------------------------------------------------------------------------
`include "ask_fsk_psk_modulator_defines.svh"

module afp_phase_gen (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_data_bit,
    input  logic             i_restart,
    input  afp_pkg::t_cfg    i_cfg,
    output afp_pkg::t_lookup o_lookup
);
    import afp_pkg::*;

    t_phase  r_carrier_phase;
    t_phase  r_tone_zero_phase;
    t_phase  r_tone_one_phase;
    t_phase  cur_carrier;
    t_phase  cur_tone_zero;
    t_phase  cur_tone_one;
    t_lookup r_lookup;
    t_lookup n_lookup;
    t_sine_addr carrier_addr;

    // restart takes effect before this tick's samples
    assign cur_carrier   = i_restart ? '0 : r_carrier_phase;
    assign cur_tone_zero = i_restart ? '0 : r_tone_zero_phase;
    assign cur_tone_one  = i_restart ? '0 : r_tone_one_phase;

    assign carrier_addr = cur_carrier[PHASE_BITS-1 -: SINE_ADDR_BITS];

    always_comb begin
        n_lookup.data_bit     = i_data_bit;
        n_lookup.carrier_addr = carrier_addr;
        n_lookup.fsk_addr     = i_data_bit ? cur_tone_one[PHASE_BITS-1 -: SINE_ADDR_BITS]
                                           : cur_tone_zero[PHASE_BITS-1 -: SINE_ADDR_BITS];
        // half a turn for a one: flip the address MSB
        n_lookup.psk_addr     = {carrier_addr[SINE_ADDR_BITS-1] ^ i_data_bit,
                                 carrier_addr[SINE_ADDR_BITS-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_phase   <= '0;
            r_tone_zero_phase <= '0;
            r_tone_one_phase  <= '0;
        end else if (i_accept) begin
            r_carrier_phase   <= cur_carrier + PHASE_BITS'(i_cfg.carrier_inc);
            r_tone_zero_phase <= cur_tone_zero + PHASE_BITS'(i_cfg.tone_zero_inc);
            r_tone_one_phase  <= cur_tone_one + PHASE_BITS'(i_cfg.tone_one_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_lookup <= n_lookup;
        end
    end

    assign o_lookup = r_lookup;

    `AFP_ASSERT_NEXT(a_restart_phase, i_clk, i_rst_n, i_accept && i_restart, r_carrier_phase == PHASE_BITS'($past(i_cfg.carrier_inc)))

endmodule

// File: design/afp_sample_calc.sv
// ---------------------------------------------------------------------------
// afp_sample_calc
// Sine lookups, ASK scaling with rounding and saturation, result register.
// ---------------------------------------------------------------------------
module afp_sample_calc (
    input  logic             i_clk,
    input  logic             i_load,
    input  afp_pkg::t_lookup i_lookup,
    input  afp_pkg::t_cfg    i_cfg,
    output afp_pkg::t_sample o_ask_sample,
    output afp_pkg::t_sample o_fsk_sample,
    output afp_pkg::t_sample o_psk_sample
);
    import afp_pkg::*;

    localparam int PROD_BITS  = AMP_BITS + 1 + SAMPLE_BITS;
    localparam int SUM_BITS   = PROD_BITS + 1;
    localparam int SHIFT_BITS = SUM_BITS - AMP_FRAC;

    localparam logic signed [SUM_BITS-1:0] ASK_ROUND = SUM_BITS'(1 << (AMP_FRAC - 1));
    localparam logic signed [SHIFT_BITS-1:0] ASK_HI =
        {{(SHIFT_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SHIFT_BITS-1:0] ASK_LO =
        {{(SHIFT_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    t_sample                      carrier;
    t_sample                      fsk;
    t_sample                      psk;
    t_amp                         amp;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [SUM_BITS-1:0]   rounded;
    logic signed [SHIFT_BITS-1:0] scaled;
    t_sample                      ask;
    t_sample                      r_ask;
    t_sample                      r_fsk;
    t_sample                      r_psk;

    assign carrier = sine_lookup(i_lookup.carrier_addr);
    assign fsk     = sine_lookup(i_lookup.fsk_addr);
    assign psk     = sine_lookup(i_lookup.psk_addr);
    assign amp     = i_lookup.data_bit ? i_cfg.amp_one : i_cfg.amp_zero;

    // Q2.14 x Q2.14, round half up, floor shift back to Q2.14
    assign prod    = $signed({1'b0, amp}) * carrier;
    assign rounded = $signed({prod[PROD_BITS-1], prod}) + ASK_ROUND;
    assign scaled  = SHIFT_BITS'(rounded >>> AMP_FRAC);

    always_comb begin
        priority if (scaled > ASK_HI) begin
            ask = ASK_HI[SAMPLE_BITS-1:0];
        end else if (scaled < ASK_LO) begin
            ask = ASK_LO[SAMPLE_BITS-1:0];
        end else begin
            ask = scaled[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ask <= ask;
            r_fsk <= fsk;
            r_psk <= psk;
        end
    end

    assign o_ask_sample = r_ask;
    assign o_fsk_sample = r_fsk;
    assign o_psk_sample = r_psk;

endmodule

// File: design/ask_fsk_psk_modulator.sv
// ---------------------------------------------------------------------------
// ask_fsk_psk_modulator
// Binary ASK / FSK / PSK modulator, one sample set per sample tick.
// ---------------------------------------------------------------------------
//  channel   dir  payload                               handshake
//  i_tick    in   data_bit, restart                      valid / ready
//  o_sample  out  ask_sample, fsk_sample, psk_sample     valid / ready
//  apb       in   5 regs at 4*i (incs, amplitudes)       psel/penable, pready = 1
//
//  One tick per cycle unless o_sample stalls; ticks pass address then output regs.
//  Stage 1 is the phase accumulators plus the address register; stage 2 is
//  the table lookups, one 16x16 multiply and the saturating round.
//  Reset (sync, active low) zeroes the phases and loads register defaults.
//  A stalled o_sample holds its word; ticks keep coming in until stage 1
//  also holds a word, then i_tick.ready drops.
// ---------------------------------------------------------------------------
`include "ask_fsk_psk_modulator_defines.svh"

module ask_fsk_psk_modulator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    afp_tick_if.sink           i_tick,
    afp_sample_if.source       o_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  afp_pkg::t_apb_addr paddr,
    input  afp_pkg::t_apb_data pwdata,
    output afp_pkg::t_apb_data prdata,
    output logic               pready
);
    import afp_pkg::*;

    t_cfg    cfg;
    t_lookup lookup;

    logic r_s1_valid;
    logic n_s1_valid;
    logic r_out_valid;
    logic n_out_valid;
    logic out_adv;     // output register may take a new word
    logic s1_adv;      // stage 1 may take a new tick
    logic load_out;
    logic tick_accept;

    afp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake: each stage moves when the one after it is empty or draining
    assign out_adv     = !r_out_valid || o_sample.ready;
    assign load_out    = r_s1_valid && out_adv;
    assign s1_adv      = !r_s1_valid || out_adv;
    assign i_tick.ready = s1_adv;
    assign tick_accept = i_tick.valid && s1_adv;

    always_comb begin
        n_s1_valid  = s1_adv ? tick_accept : r_s1_valid;
        n_out_valid = out_adv ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // stage 1: phases advance on accept, addresses registered
    afp_phase_gen u_phase_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (tick_accept),
        .i_data_bit (i_tick.data_bit),
        .i_restart  (i_tick.restart),
        .i_cfg      (cfg),
        .o_lookup   (lookup)
    );

    // stage 2: lookups and ASK scaling into the output register
    afp_sample_calc u_sample_calc (
        .i_clk        (i_clk),
        .i_load       (load_out),
        .i_lookup     (lookup),
        .i_cfg        (cfg),
        .o_ask_sample (o_sample.ask_sample),
        .o_fsk_sample (o_sample.fsk_sample),
        .o_psk_sample (o_sample.psk_sample)
    );

    assign o_sample.valid = r_out_valid;

    `AFP_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, tick_accept, r_s1_valid)
    `AFP_ASSERT_IMPL(a_full_blocks_input, i_clk, i_rst_n, r_s1_valid && r_out_valid && !o_sample.ready, !i_tick.ready)
    `AFP_ASSERT_NEXT(a_drain_empties_out, i_clk, i_rst_n, r_out_valid && o_sample.ready && !r_s1_valid, !r_out_valid)

endmodule

// File: bench/ask_fsk_psk_modulator_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ask_fsk_psk_modulator_checker
// Watches the tick, sample and register ports of the modulator, predicts
// every sample set from its own copy of the phases and registers, and
// compares each output word with the oldest prediction.
// ---------------------------------------------------------------------------
module ask_fsk_psk_modulator_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    afp_tick_if                i_tick,
    afp_sample_if              i_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  afp_pkg::t_apb_addr paddr,
    input  afp_pkg::t_apb_data pwdata,
    output int                 o_fail_count,
    output int                 o_outstanding
);
    import afp_pkg::*;

    typedef longint unsigned u64;

    typedef struct packed {
        t_sample ask;
        t_sample fsk;
        t_sample psk;
    } t_sample_set;

    // table build: Q30 angle and unit, rounding shift down to the sample format
    localparam u64     PI_FIX     = 64'd3373259426;
    localparam u64     UNIT_FIX   = 64'd1 << 30;
    localparam int     FIX_SHIFT  = 30 - (SAMPLE_BITS - 2);
    localparam u64     FULL_SCALE = 64'd1 << (SAMPLE_BITS - 2);

    localparam t_phase HALF_TURN  = t_phase'(1) << (PHASE_BITS - 1);
    localparam longint ASK_ROUND  = longint'(1) << (AMP_FRAC - 1);
    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) << (SAMPLE_BITS - 1));

    int          quarter_sine [0:QUARTER_LEN];
    t_sample_set expected_sets [$];

    t_phase carrier_phase;
    t_phase tone_zero_phase;
    t_phase tone_one_phase;
    t_inc   carrier_step;
    t_inc   tone_zero_step;
    t_inc   tone_one_step;
    t_amp   amp_zero;
    t_amp   amp_one;

    initial begin : build_quarter_sine
        u64     x;
        u64     x2;
        u64     term;
        u64     s;
        longint sum;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            x    = (u64'(k) * PI_FIX) / u64'(2 * QUARTER_LEN);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int j = 1; j <= 9; j++) begin
                term = (term * x2) / u64'((2 * j) * (2 * j + 1));
                term = term >> 30;
                if ((j % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            s = (sum < 0) ? 64'd0 : u64'(sum);
            if (s > UNIT_FIX) begin
                s = UNIT_FIX;
            end
            s = (s + (u64'(1) << (FIX_SHIFT - 1))) >> FIX_SHIFT;
            if (s > FULL_SCALE) begin
                s = FULL_SCALE;
            end
            quarter_sine[k] = int'(s);
        end
    end

    // quadrant fold of the quarter table
    function automatic longint sine_at(t_phase ph);
        t_sine_addr              addr;
        logic [1:0]              quad;
        logic [QUARTER_BITS-1:0] idx;
        longint                  mag;
        addr = ph[PHASE_BITS-1 -: SINE_ADDR_BITS];
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        idx  = addr[QUARTER_BITS-1:0];
        mag  = quad[0] ? quarter_sine[QUARTER_LEN - int'(idx)] : quarter_sine[idx];
        return quad[1] ? -mag : mag;
    endfunction

    function automatic t_sample clip_sample(longint v);
        if (v > SAMPLE_MAX) begin
            return t_sample'(SAMPLE_MAX);
        end
        if (v < SAMPLE_MIN) begin
            return t_sample'(SAMPLE_MIN);
        end
        return t_sample'(v);
    endfunction

    // one tick: restart, samples from the current phases, then advance
    function automatic t_sample_set modulate_tick(logic bit_v, logic restart_v);
        t_sample_set s;
        longint      carrier;
        longint      product;
        if (restart_v) begin
            carrier_phase   = '0;
            tone_zero_phase = '0;
            tone_one_phase  = '0;
        end
        carrier = sine_at(carrier_phase);
        product = longint'(bit_v ? amp_one : amp_zero) * carrier;
        s.ask   = clip_sample((product + ASK_ROUND) >>> AMP_FRAC);
        s.fsk   = clip_sample(sine_at(bit_v ? tone_one_phase : tone_zero_phase));
        s.psk   = clip_sample(sine_at(bit_v ? carrier_phase + HALF_TURN : carrier_phase));
        carrier_phase   = carrier_phase + carrier_step;
        tone_zero_phase = tone_zero_phase + tone_zero_step;
        tone_one_phase  = tone_one_phase + tone_one_step;
        return s;
    endfunction

    task automatic check_field(input string field, input t_sample want, input t_sample got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s sample mismatch, expected %0d, got %0d",
                     $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_sample_set want;
        if (!i_rst_n) begin
            carrier_phase   = '0;
            tone_zero_phase = '0;
            tone_one_phase  = '0;
            carrier_step    = RST_CARRIER_INC;
            tone_zero_step  = RST_TONE_ZERO_INC;
            tone_one_step   = RST_TONE_ONE_INC;
            amp_zero        = RST_AMP_ZERO;
            amp_one         = RST_AMP_ONE;
            expected_sets.delete();
            o_fail_count    = 0;
            o_outstanding   = 0;
        end else begin
            if (i_sample.valid && i_sample.ready) begin
                if (expected_sets.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected sample word, expected none, got %0d %0d %0d",
                             $time, i_sample.ask_sample, i_sample.fsk_sample,
                             i_sample.psk_sample);
                end else begin
                    want = expected_sets.pop_front();
                    check_field("ask", want.ask, i_sample.ask_sample);
                    check_field("fsk", want.fsk, i_sample.fsk_sample);
                    check_field("psk", want.psk, i_sample.psk_sample);
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                expected_sets.push_back(modulate_tick(i_tick.data_bit, i_tick.restart));
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_ADDR_BITS-1:2]))
                    REG_CARRIER_INC:   carrier_step   = t_inc'(pwdata);
                    REG_TONE_ZERO_INC: tone_zero_step = t_inc'(pwdata);
                    REG_TONE_ONE_INC:  tone_one_step  = t_inc'(pwdata);
                    REG_AMP_ZERO:      amp_zero       = pwdata[AMP_BITS-1:0];
                    REG_AMP_ONE:       amp_one        = pwdata[AMP_BITS-1:0];
                    default: ;
                endcase
            end
            o_outstanding = expected_sets.size();
        end
    end

endmodule

// File: bench/ask_fsk_psk_modulator_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ask_fsk_psk_modulator_tb
// Drives sample ticks and register writes into the modulator, with random
// gaps on both channels, and lets the checker judge every output word.
// ---------------------------------------------------------------------------
module ask_fsk_psk_modulator_tb;
    import afp_pkg::*;

    localparam int        TIMEOUT_CYCLES  = 200000;
    localparam int        HOLD_CYCLES     = 64;   // long receiver stall, fills the pipe
    localparam int        ITEMS_PER_ROUND = 100;
    localparam int        END_CYCLES      = 4;    // settle after the last word
    // index 7: past the end of the register map, must be ignored
    localparam t_apb_addr UNMAPPED_ADDR   = 5'd28;

    logic      i_clk;
    logic      i_rst_n;
    logic      psel;
    logic      penable;
    logic      pwrite;
    t_apb_addr paddr;
    t_apb_data pwdata;
    t_apb_data prdata;
    logic      pready;

    int fail_count;
    int outstanding;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int cycle_count;

    afp_tick_if   tick_ch();
    afp_sample_if sample_ch();

    ask_fsk_psk_modulator i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_ch),
        .o_sample (sample_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ask_fsk_psk_modulator_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (tick_ch),
        .i_sample      (sample_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure at rx_idle_pct. A bump of hold_requests
    // from the stimulus starts a long stall, counted here, while the sender
    // keeps offering ticks.
    initial begin : receiver
        int unsigned hold_left;
        int          holds_served;
        hold_left       = 0;
        holds_served    = 0;
        sample_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                sample_ch.ready <= 1'b0;
            end else begin
                sample_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** ask_fsk_psk_modulator: FAILED **");
        $finish;
    end

    function automatic t_apb_addr reg_addr(t_reg_idx idx);
        return t_apb_addr'({idx, 2'b00});
    endfunction

    // amplitude word with junk above the 15 valid bits; the block masks them
    function automatic t_apb_data amp_word(t_amp amp);
        t_apb_data data;
        data              = $urandom;
        data[AMP_BITS-1:0] = amp;
        return data;
    endfunction

    function automatic t_inc rand_step();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return t_inc'($urandom_range(32'h00FF_FFFF));
            default: return t_inc'($urandom);
        endcase
    endfunction

    function automatic t_amp rand_amp();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            default: return t_amp'($urandom_range(32767));
        endcase
    endfunction

    // One APB write, entered and left at a falling edge. psel stays high so
    // back-to-back writes need no lowering in between.
    task automatic write_reg(input t_apb_addr addr, input t_apb_data data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
    endtask

    task automatic set_registers(input t_inc carrier, input t_inc tone_zero,
                                 input t_inc tone_one, input t_amp zero_amp,
                                 input t_amp one_amp);
        write_reg(reg_addr(REG_CARRIER_INC), carrier);
        write_reg(reg_addr(REG_TONE_ZERO_INC), tone_zero);
        write_reg(reg_addr(REG_TONE_ONE_INC), tone_one);
        write_reg(reg_addr(REG_AMP_ZERO), amp_word(zero_amp));
        write_reg(reg_addr(REG_AMP_ONE), amp_word(one_amp));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One tick word. Idle cycles first, each drawn at tx_idle_pct, then hold
    // valid until accepted. Leaves at a falling edge with valid still high
    // for back-to-back words.
    task automatic send_tick(input logic bit_v, input logic restart_v);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_ch.valid    <= 1'b1;
        tick_ch.data_bit <= bit_v;
        tick_ch.restart  <= restart_v;
        do @(posedge i_clk); while (!(tick_ch.valid && tick_ch.ready));
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every predicted word has come out.
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    initial begin : stimulus
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        tick_ch.valid    = 1'b0;
        tick_ch.data_bit = 1'b0;
        tick_ch.restart  = 1'b0;
        tx_idle_pct      = 0;
        rx_idle_pct      = 0;
        hold_requests    = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, reset registers ---
        // restart puts every phase at zero: sin(0) is exactly 0 everywhere
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        // restart with a one: PSK is sin(pi), the negated zero
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        wait_drained();

        // quarter-turn carrier lands on the table ends (peaks and zero
        // crossings, mirrored quadrants); full-scale amplitude for a one
        // pushes ASK to the top of the range; frozen zero tone, max-step one tone
        set_registers(32'h4000_0000, '0, '1, '0, '1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        wait_drained();

        // mirrored extremes, plus a write past the register map
        write_reg(UNMAPPED_ADDR, $urandom);
        set_registers('1, 32'h8000_0000, '0, '1, '0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);

        // --- random: three idling profiles, four register settings each ---
        for (int seg = 0; seg < 3; seg++) begin
            case (seg)
                0: begin
                    tx_idle_pct = 28;
                    rx_idle_pct = 51;
                end
                1: begin
                    tx_idle_pct = 51;
                    rx_idle_pct = 28;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int round = 0; round < 4; round++) begin
                // registers only change with the pipe empty
                wait_drained();
                set_registers(rand_step(), rand_step(), rand_step(), rand_amp(), rand_amp());
                for (int n = 0; n < ITEMS_PER_ROUND; n++) begin
                    // full-rate sender against a long receiver stall
                    if (seg == 2 && round == 1 && n == 20) begin
                        hold_requests++;
                    end
                    // sender pause mid-stream until the pipe is empty
                    if (seg == 2 && round == 2 && n == 50) begin
                        wait_drained();
                    end
                    send_tick($urandom_range(1), $urandom_range(39) == 0);
                end
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** ask_fsk_psk_modulator: PASSED **");
        end else begin
            $display("** ask_fsk_psk_modulator: FAILED **");
        end
        $finish;
    end

endmodule
